FILE: hw/rtl/rpr_pkg.sv
package rpr_pkg;

  // Width of the CORDIC x and y registers (Q1.15 with growth headroom).
  localparam int XY_W = 18;
  // Width of the residual angle in Q0.32 turns plus sign and headroom.
  localparam int Z_W = 34;
  // Width of the per-pair step in Q0.48 turns per position.
  localparam int STEP_W = 46;
  localparam int CORDIC_ITERS = 16;
  localparam int ITER_PER_STAGE = 4;
  localparam int PAIR_ENTRIES = 128;

  localparam logic [63:0] INV_TWO_PI_Q32 = 64'd683565276;
  localparam logic signed [XY_W-1:0] CORDIC_X0 = 18'sd19898;

  localparam logic [31:0] ATAN_TURNS [CORDIC_ITERS] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861
  };

  typedef struct packed {
    logic valid;
    logic flip;
    logic err;
  } rpr_ctl_t;

endpackage

FILE: hw/rtl/rpr_cordic_stage.sv
module rpr_cordic_stage #(
  parameter int FIRST = 0
) (
  input  logic                              clk,
  input  logic                              rst,
  input  rpr_pkg::rpr_ctl_t                 ctl_in,
  input  logic signed [rpr_pkg::XY_W-1:0]   x_in,
  input  logic signed [rpr_pkg::XY_W-1:0]   y_in,
  input  logic signed [rpr_pkg::Z_W-1:0]    z_in,
  output rpr_pkg::rpr_ctl_t                 ctl_out,
  output logic signed [rpr_pkg::XY_W-1:0]   x_out,
  output logic signed [rpr_pkg::XY_W-1:0]   y_out,
  output logic signed [rpr_pkg::Z_W-1:0]    z_out
);
  import rpr_pkg::*;

  logic signed [XY_W-1:0] x_next;
  logic signed [XY_W-1:0] y_next;
  logic signed [Z_W-1:0]  z_next;

  always_comb begin
    logic signed [XY_W-1:0] xv;
    logic signed [XY_W-1:0] yv;
    logic signed [XY_W-1:0] xn;
    logic signed [Z_W-1:0]  zv;
    logic signed [Z_W-1:0]  at;
    xv = x_in;
    yv = y_in;
    zv = z_in;
    for (int k = 0; k < ITER_PER_STAGE; k++) begin
      at = signed'(Z_W'(ATAN_TURNS[FIRST + k]));
      if (!zv[Z_W-1]) begin
        xn = xv - (yv >>> (FIRST + k));
        yv = yv + (xv >>> (FIRST + k));
        zv = zv - at;
      end else begin
        xn = xv + (yv >>> (FIRST + k));
        yv = yv - (xv >>> (FIRST + k));
        zv = zv + at;
      end
      xv = xn;
    end
    x_next = xv;
    y_next = yv;
    z_next = zv;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else begin
      ctl_out <= ctl_in;
    end
    x_out <= x_next;
    y_out <= y_next;
    z_out <= z_next;
  end

endmodule

FILE: hw/rtl/rotary_position_rotate_pair.sv
// Rotary position embedding for one element pair per request, half-split layout.
// The block is a fixed pipeline: a request is taken in every cycle that start is
// high, busy is always low, and each result appears on the result ports with done
// high for exactly one cycle, in request order. The pipeline is made of the step
// table lookup, the phase multiply, four CORDIC stages of four iterations each, the
// rotation multiplies and the final round and saturate stage. The result ports must
// be sampled when done is high; results are never held.
module rotary_position_rotate_pair #(
  parameter int HEAD_SIZE  = 128,
  parameter int ROPE_BASE  = 10000,
  parameter int DATA_WIDTH = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [6:0]                   pair_index,
  input  logic [15:0]                  position,
  input  logic signed [DATA_WIDTH-1:0] first_value,
  input  logic signed [DATA_WIDTH-1:0] second_value,
  output logic                         done,
  output logic signed [DATA_WIDTH-1:0] first_result,
  output logic signed [DATA_WIDTH-1:0] second_result,
  output logic                         index_error
);
  import rpr_pkg::*;

  localparam int DW = DATA_WIDTH;
  localparam int AB_DEPTH = 6;

  typedef logic [STEP_W-1:0] step_tab_t [PAIR_ENTRIES];

  function automatic logic [63:0] isqrt64(input logic [63:0] n_in);
    logic [63:0] n;
    logic [63:0] r;
    logic [63:0] bits;
    n = n_in;
    r = 64'd0;
    bits = 64'd1 << 62;
    while (bits > n) bits = bits >> 2;
    while (bits != 64'd0) begin
      if (n >= r + bits) begin
        n = n - (r + bits);
        r = (r >> 1) + bits;
      end else begin
        r = r >> 1;
      end
      bits = bits >> 2;
    end
    return r;
  endfunction

  function automatic logic [63:0] log2_base_q30();
    logic [63:0] b;
    logic [63:0] y;
    logic [63:0] frac;
    int n;
    b = 64'(ROPE_BASE);
    frac = 64'd0;
    n = 0;
    if (b < 64'd2) return 64'd0;
    while ((b >> (n + 1)) != 64'd0) n++;
    y = (n >= 30) ? (b >> (n - 30)) : (b << (30 - n));
    for (int k = 0; k < 30; k++) begin
      y = (y * y) >> 30;
      frac = frac << 1;
      if (y >= (64'd1 << 31)) begin
        frac = frac | 64'd1;
        y = y >> 1;
      end
    end
    return (64'(n) << 30) | frac;
  endfunction

  function automatic step_tab_t build_steps();
    step_tab_t   tab;
    logic [63:0] lq;
    logic [63:0] e;
    logic [63:0] ei;
    logic [63:0] ef;
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] prod;
    lq = log2_base_q30();
    for (int d = 0; d < PAIR_ENTRIES; d++) begin
      if (d < HEAD_SIZE / 2) begin
        e = (lq * 64'(2 * d)) / 64'(HEAD_SIZE);
        ei = e >> 30;
        ef = e & ((64'd1 << 30) - 64'd1);
        v = 64'd1 << 32;
        r = isqrt64(64'd1 << 63);
        for (int k = 1; k <= 30; k++) begin
          if (ef[30-k]) v = (v * r) >> 32;
          r = isqrt64(r << 32);
        end
        v = (ei >= 64'd64) ? 64'd0 : (v >> ei);
        prod = (v * INV_TWO_PI_Q32) >> 16;
        tab[d] = prod[STEP_W-1:0];
      end else begin
        tab[d] = '0;
      end
    end
    return tab;
  endfunction

  localparam step_tab_t STEP_TABLE = build_steps();

  localparam logic signed [DW+18:0] ROUND_HALF = (DW+19)'(16384);
  localparam logic signed [DW+18:0] SAT_MAX = (DW+19)'((64'sd1 <<< (DW - 1)) - 64'sd1);
  localparam logic signed [DW+18:0] SAT_MIN = -((DW+19)'(64'sd1 <<< (DW - 1)));

  // Stage 1: registered request and its step from the table.
  logic              s1_valid;
  logic              s1_err;
  logic [15:0]       s1_pos;
  logic [STEP_W-1:0] s1_step;
  // Stage 2: phase in Q0.32 turns.
  logic              s2_valid;
  logic              s2_err;
  logic [31:0]       s2_phase;

  logic signed [DW-1:0] a_d [AB_DEPTH];
  logic signed [DW-1:0] b_d [AB_DEPTH];

  logic [STEP_W+15:0] phase_prod;
  assign phase_prod = (STEP_W+16)'(s1_pos) * (STEP_W+16)'(s1_step);

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= start;
      s2_valid <= s1_valid;
    end
    s1_err   <= (8'(pair_index) >= 8'(HEAD_SIZE / 2));
    s1_pos   <= position;
    s1_step  <= STEP_TABLE[pair_index];
    s2_err   <= s1_err;
    s2_phase <= phase_prod[47:16];
    a_d[0]   <= first_value;
    b_d[0]   <= second_value;
    for (int k = 1; k < AB_DEPTH; k++) begin
      a_d[k] <= a_d[k-1];
      b_d[k] <= b_d[k-1];
    end
  end

  // Quadrant fold: quadrants one and two move by half a turn and flip sign later.
  logic        fold_flip;
  logic [31:0] fold_phase;
  assign fold_flip  = s2_phase[31] ^ s2_phase[30];
  assign fold_phase = fold_flip ? (s2_phase ^ 32'h8000_0000) : s2_phase;

  rpr_ctl_t               c_ctl [5];
  logic signed [XY_W-1:0] c_x   [5];
  logic signed [XY_W-1:0] c_y   [5];
  logic signed [Z_W-1:0]  c_z   [4];

  assign c_ctl[0] = '{valid: s2_valid, flip: fold_flip, err: s2_err};
  assign c_x[0]   = CORDIC_X0;
  assign c_y[0]   = '0;
  assign c_z[0]   = Z_W'(signed'(fold_phase));

  for (genvar g = 0; g < 3; g++) begin : g_cordic
    rpr_cordic_stage #(.FIRST(g * ITER_PER_STAGE)) u_stage (
      .clk     (clk),
      .rst     (rst),
      .ctl_in  (c_ctl[g]),
      .x_in    (c_x[g]),
      .y_in    (c_y[g]),
      .z_in    (c_z[g]),
      .ctl_out (c_ctl[g+1]),
      .x_out   (c_x[g+1]),
      .y_out   (c_y[g+1]),
      .z_out   (c_z[g+1])
    );
  end

  rpr_cordic_stage #(.FIRST(3 * ITER_PER_STAGE)) u_stage_last (
    .clk     (clk),
    .rst     (rst),
    .ctl_in  (c_ctl[3]),
    .x_in    (c_x[3]),
    .y_in    (c_y[3]),
    .z_in    (c_z[3]),
    .ctl_out (c_ctl[4]),
    .x_out   (c_x[4]),
    .y_out   (c_y[4]),
    .z_out   ()
  );

  logic signed [XY_W-1:0] cos_v;
  logic signed [XY_W-1:0] sin_v;
  assign cos_v = c_ctl[4].flip ? -c_x[4] : c_x[4];
  assign sin_v = c_ctl[4].flip ? -c_y[4] : c_y[4];

  // Multiply stage.
  logic                 m_valid;
  logic                 m_err;
  logic signed [DW-1:0] m_a;
  logic signed [DW-1:0] m_b;
  logic signed [DW+17:0] p_ac;
  logic signed [DW+17:0] p_bs;
  logic signed [DW+17:0] p_bc;
  logic signed [DW+17:0] p_as;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else begin
      m_valid <= c_ctl[4].valid;
    end
    m_err <= c_ctl[4].err;
    m_a   <= a_d[AB_DEPTH-1];
    m_b   <= b_d[AB_DEPTH-1];
    p_ac  <= (DW+18)'(a_d[AB_DEPTH-1]) * (DW+18)'(cos_v);
    p_bs  <= (DW+18)'(b_d[AB_DEPTH-1]) * (DW+18)'(sin_v);
    p_bc  <= (DW+18)'(b_d[AB_DEPTH-1]) * (DW+18)'(cos_v);
    p_as  <= (DW+18)'(a_d[AB_DEPTH-1]) * (DW+18)'(sin_v);
  end

  logic signed [DW+18:0] sum_first;
  logic signed [DW+18:0] sum_second;
  logic signed [DW+18:0] rnd_first;
  logic signed [DW+18:0] rnd_second;
  logic signed [DW+18:0] sat_first;
  logic signed [DW+18:0] sat_second;

  always_comb begin
    sum_first  = (DW+19)'(p_ac) - (DW+19)'(p_bs);
    sum_second = (DW+19)'(p_bc) + (DW+19)'(p_as);
    rnd_first  = (sum_first + ROUND_HALF) >>> 15;
    rnd_second = (sum_second + ROUND_HALF) >>> 15;
    if (rnd_first > SAT_MAX) sat_first = SAT_MAX;
    else if (rnd_first < SAT_MIN) sat_first = SAT_MIN;
    else sat_first = rnd_first;
    if (rnd_second > SAT_MAX) sat_second = SAT_MAX;
    else if (rnd_second < SAT_MIN) sat_second = SAT_MIN;
    else sat_second = rnd_second;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= m_valid;
    end
    index_error <= m_err;
    if (m_err) begin
      first_result  <= m_a;
      second_result <= m_b;
    end else begin
      first_result  <= sat_first[DW-1:0];
      second_result <= sat_second[DW-1:0];
    end
  end

endmodule

FILE: dv/rotary_position_rotate_pair_tb.sv
`timescale 1ns / 1ps

module rotary_position_rotate_pair_tb;

  localparam int HEAD_SIZE  = 128;
  localparam int ROPE_BASE  = 10000;
  localparam int DATA_WIDTH = 16;
  localparam int LATENCY    = 8;
  localparam int RANDOM_ITEMS = 1050;

  typedef struct {
    logic signed [DATA_WIDTH-1:0] first_result;
    logic signed [DATA_WIDTH-1:0] second_result;
    logic                         index_error;
  } rotated_pair_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [6:0] pair_index = '0;
  logic [15:0] position = '0;
  logic signed [DATA_WIDTH-1:0] first_value = '0;
  logic signed [DATA_WIDTH-1:0] second_value = '0;
  logic done;
  logic signed [DATA_WIDTH-1:0] first_result;
  logic signed [DATA_WIDTH-1:0] second_result;
  logic index_error;

  rotary_position_rotate_pair #(
    .HEAD_SIZE(HEAD_SIZE), .ROPE_BASE(ROPE_BASE), .DATA_WIDTH(DATA_WIDTH)
  ) uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .pair_index(pair_index), .position(position),
    .first_value(first_value), .second_value(second_value),
    .done(done), .first_result(first_result),
    .second_result(second_result), .index_error(index_error)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Turns per position in Q0.48 for each pair index, filled at time zero.
  logic [63:0] turn_step [HEAD_SIZE/2];

  function automatic logic [63:0] int_sqrt(logic [63:0] n);
    logic [63:0] r, bits;
    r = 0;
    bits = 64'd1 << 62;
    while (bits > n) bits = bits >> 2;
    while (bits != 0) begin
      if (n >= r + bits) begin
        n = n - (r + bits);
        r = (r >> 1) + bits;
      end else begin
        r = r >> 1;
      end
      bits = bits >> 2;
    end
    return r;
  endfunction

  function automatic logic [63:0] log2_q30(logic [63:0] b);
    int n;
    logic [63:0] m, frac;
    n = 0;
    frac = 0;
    if (b < 2) return 0;
    while ((b >> (n + 1)) != 0) n++;
    m = (n >= 30) ? (b >> (n - 30)) : (b << (30 - n));
    for (int k = 0; k < 30; k++) begin
      m = (m * m) >> 30;
      frac = frac << 1;
      if (m >= (64'd1 << 31)) begin
        frac[0] = 1'b1;
        m = m >> 1;
      end
    end
    return (64'(n) << 30) | frac;
  endfunction

  function automatic logic [63:0] pair_step(int d);
    logic [63:0] e, ei, ef, v, r;
    e = log2_q30(64'(ROPE_BASE)) * 64'(2 * d) / 64'(HEAD_SIZE);
    ei = e >> 30;
    ef = e & ((64'd1 << 30) - 1);
    v = 64'd1 << 32;
    r = int_sqrt(64'd1 << 63);
    for (int k = 1; k <= 30; k++) begin
      if (ef[30-k]) v = (v * r) >> 32;
      r = int_sqrt(r << 32);
    end
    v = (ei >= 64) ? 64'd0 : (v >> ei);
    return (v * rpr_pkg::INV_TWO_PI_Q32) >> 16;
  endfunction

  function automatic logic signed [DATA_WIDTH-1:0] round_saturate(longint sum);
    longint v, hi, lo;
    hi = (longint'(1) << (DATA_WIDTH - 1)) - 1;
    lo = -(longint'(1) << (DATA_WIDTH - 1));
    v = (sum + (longint'(1) << 14)) >>> 15;
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    return v[DATA_WIDTH-1:0];
  endfunction

  function automatic rotated_pair_t rotate_pair(logic [6:0] d, logic [15:0] pos,
      logic signed [DATA_WIDTH-1:0] a, logic signed [DATA_WIDTH-1:0] b);
    rotated_pair_t res;
    logic [63:0] prod;
    logic [31:0] ph;
    logic flip;
    longint x, y, z, dx, dy, c, s, av, bv;
    av = a;
    bv = b;
    if (d >= HEAD_SIZE / 2) begin
      res.first_result = a;
      res.second_result = b;
      res.index_error = 1'b1;
      return res;
    end
    prod = 64'(pos) * turn_step[d];
    ph = prod[47:16];
    flip = (ph[31:30] == 2'b01) || (ph[31:30] == 2'b10);
    if (flip) ph = ph - 32'h8000_0000;
    z = longint'($signed(ph));
    x = rpr_pkg::CORDIC_X0;
    y = 0;
    for (int i = 0; i < rpr_pkg::CORDIC_ITERS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(rpr_pkg::ATAN_TURNS[i]);
      end else begin
        x += dx; y -= dy; z += longint'(rpr_pkg::ATAN_TURNS[i]);
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
    res.first_result = round_saturate(av * c - bv * s);
    res.second_result = round_saturate(bv * c + av * s);
    res.index_error = 1'b0;
    return res;
  endfunction

  class rotation_scoreboard;
    rotated_pair_t pending[$];
    int mismatches = 0;
    int checked = 0;
    int errors_seen = 0;

    function void note_request(logic [6:0] d, logic [15:0] pos,
        logic signed [DATA_WIDTH-1:0] a, logic signed [DATA_WIDTH-1:0] b);
      pending.push_back(rotate_pair(d, pos, a, b));
    endfunction

    function void check_result(rotated_pair_t got);
      rotated_pair_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result %0d %0d err=%0b",
            got.first_result, got.second_result, got.index_error);
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got.index_error) errors_seen++;
      if (got.first_result !== want.first_result ||
          got.second_result !== want.second_result ||
          got.index_error !== want.index_error) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Mismatch: expected %0d %0d err=%0b, got %0d %0d err=%0b",
              want.first_result, want.second_result, want.index_error,
              got.first_result, got.second_result, got.index_error);
      end
    endfunction
  endclass

  rotation_scoreboard board = new();
  int send_idle_pct = 0;

  always @(posedge clk) begin
    if (!rst && done)
      board.check_result('{first_result, second_result, index_error});
  end

  // Presents one request and holds it until the block takes it.
  task automatic send_request(logic [6:0] d, logic [15:0] pos,
      logic [DATA_WIDTH-1:0] a, logic [DATA_WIDTH-1:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    pair_index <= d;
    position <= pos;
    first_value <= a;
    second_value <= b;
    do @(posedge clk); while (busy);
    board.note_request(d, pos, a, b);
  endtask

  task automatic send_random();
    logic [6:0] d;
    logic [15:0] pos;
    case ($urandom_range(9))
      0: d = 7'($urandom_range(HEAD_SIZE / 2, 127));
      1: d = 7'($urandom_range(0, 3));
      default: d = 7'($urandom_range(0, HEAD_SIZE / 2 - 1));
    endcase
    pos = ($urandom_range(3) == 0) ? 16'($urandom_range(0, 64)) : 16'($urandom);
    send_request(d, pos, 16'($urandom), 16'($urandom));
  endtask

  initial begin
    int wait_cycles;
    for (int d = 0; d < HEAD_SIZE / 2; d++) turn_step[d] = pair_step(d);
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_request(0, 0, 16'h7fff, 16'h8000);
    send_request(0, 1, 16'h0100, 16'h0000);
    send_request(0, 16'hffff, 16'h7fff, 16'h7fff);
    send_request(0, 2, 16'h8000, 16'h8000);
    send_request(0, 3, 16'h8000, 16'h7fff);
    send_request(1, 100, 16'h0100, 16'hff00);
    send_request(63, 16'hffff, 16'h7fff, 16'h8000);
    send_request(63, 0, 16'h1234, 16'hedcb);
    send_request(31, 12345, 16'h0000, 16'h0000);
    send_request(64, 16'hffff, 16'h8000, 16'h7fff);
    send_request(127, 0, 16'h7fff, 16'h8000);
    send_request(100, 16'h5555, 16'haaaa, 16'h5555);
    send_request(7'h55, 16'haaaa, 16'h5555, 16'haaaa);
    send_request(7'h2a, 16'h5555, 16'hffff, 16'h0001);

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 35 : (phase == 1) ? 86 : 0;
      for (int n = 0; n < RANDOM_ITEMS / 3; n++) begin
        if ($urandom_range(19) == 0) begin
          start <= 1'b0;
          repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        send_random();
      end
    end
    start <= 1'b0;

    wait_cycles = 0;
    while (board.pending.size() != 0 && wait_cycles < 1000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (LATENCY + 4) @(posedge clk);
    if (board.pending.size() != 0) board.mismatches++;

    $display("Checked %0d rotated pairs, %0d of them with an out-of-range pair index.",
        board.checked, board.errors_seen);
    $display("Positions, pair indexes and values covered extremes and random content.");
    if (board.mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/rpr_pkg.sv
hw/rtl/rpr_cordic_stage.sv
hw/rtl/rotary_position_rotate_pair.sv
dv/rotary_position_rotate_pair_tb.sv
